// ===== design/kfi_pkg.sv =====
// Shared types and constants for the keyframe interpolation block.
`timescale 1ns / 1ps
`default_nettype none
package kfi_pkg;

  localparam int TimeW  = 24;
  localparam int ValW   = 32;
  localparam int CountW = 7;
  localparam int IdxW   = 6;
  localparam int FracW  = 16;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Item passed from the front to the back through the queue.
  typedef struct packed {
    logic             is_query;
    logic [IdxW-1:0]  key_index;
    logic [TimeW-1:0] key_time;
    logic [ValW-1:0]  value_x;
    logic [ValW-1:0]  value_y;
    logic [ValW-1:0]  value_z;
    logic [TimeW-1:0] query_time;
  } kfi_item_t;

endpackage
`default_nettype wire

// ===== design/kfi_front.sv =====
// Front end: accepts items, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module kfi_front import kfi_pkg::*; #(
  parameter int Depth = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  output logic                  full,
  input  wire logic             op,
  input  wire logic [IdxW-1:0]  key_index,
  input  wire logic [TimeW-1:0] key_time,
  input  wire logic [ValW-1:0]  value_x,
  input  wire logic [ValW-1:0]  value_y,
  input  wire logic [ValW-1:0]  value_z,
  input  wire logic [TimeW-1:0] query_time,
  output logic                  q_valid,
  output kfi_item_t             q_item,
  input  wire logic             q_take
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  kfi_item_t         fifo [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [PtrW:0]     fill;
  logic              do_push;
  logic              do_pop;
  kfi_item_t         item_in;

  assign full    = (fill == (PtrW+1)'(Depth));
  assign q_valid = (fill != '0);
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;
  assign q_item  = fifo[rd_ptr];

  always_comb begin
    item_in.is_query   = (op_t'(op) == OP_QUERY);
    item_in.key_index  = key_index;
    item_in.key_time   = key_time;
    item_in.value_x    = value_x;
    item_in.value_y    = value_y;
    item_in.value_z    = value_z;
    item_in.query_time = query_time;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      fifo[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (PtrW+1)'(Depth)) else $error("queue overfilled");
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (fill == $past(fill) + 1'b1))
    else $error("fill count did not advance");
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (fill == '0) |-> !do_pop) else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== design/kfi_divider.sv =====
// Restoring divider: quotient of (num << 16) / den, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module kfi_divider import kfi_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [TimeW-1:0] num,
  input  wire logic [TimeW-1:0] den,
  output logic                  done,
  output logic [FracW-1:0]      quot
);

  localparam int CntW = $clog2(FracW + 1);

  logic [TimeW:0]    rem;
  logic [TimeW-1:0]  dsr;
  logic [CntW-1:0]   cnt;
  logic              busy;
  logic [TimeW+1:0]  trial;

  assign trial = {rem, 1'b0} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(FracW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // num < den holds, so the remainder stays below 2*den.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, num};
      dsr  <= den;
      quot <= '0;
    end else if (busy) begin
      if (!trial[TimeW+1]) begin
        rem  <= trial[TimeW:0];
        quot <= {quot[FracW-2:0], 1'b1};
      end else begin
        rem  <= {rem[TimeW-1:0], 1'b0};
        quot <= {quot[FracW-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/kfi_back.sv =====
// Back end: key store, interval scan, factor division and interpolation.
`timescale 1ns / 1ps
`default_nettype none
module kfi_back import kfi_pkg::*; #(
  parameter int MaxKeys = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CountW-1:0] cfg_data,
  input  wire logic              q_valid,
  input  wire kfi_item_t         q_item,
  output logic                   q_take,
  output logic                   empty,
  input  wire logic              pop,
  output logic [ValW-1:0]        out_x,
  output logic [ValW-1:0]        out_y,
  output logic [ValW-1:0]        out_z,
  output logic [IdxW-1:0]        interval_start,
  output logic                   out_of_range
);

  localparam int AW = $clog2(MaxKeys);
  localparam int NW = $clog2(MaxKeys + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD    = 9'b000000010,
    S_SCAN  = 9'b000000100,
    S_FETCH = 9'b000001000,
    S_PAIR  = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_SUM   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;

  logic [TimeW-1:0] mem_t [MaxKeys];
  logic [ValW-1:0]  mem_x [MaxKeys];
  logic [ValW-1:0]  mem_y [MaxKeys];
  logic [ValW-1:0]  mem_z [MaxKeys];

  logic [CountW-1:0] key_count;
  logic [NW-1:0]     n_eff;
  logic [AW-1:0]     rd_addr;
  logic [TimeW-1:0]  rd_t;
  logic [ValW-1:0]   rd_x, rd_y, rd_z;
  logic [AW-1:0]     scan;
  logic [AW-1:0]     lo;
  logic [TimeW-1:0]  qt;
  logic [TimeW-1:0]  t0;
  logic [ValW-1:0]   s_x, s_y, s_z;
  logic [ValW-1:0]   r_x, r_y, r_z;
  logic              have_lo_row;
  logic [FracW:0]    factor;
  logic              flag;
  logic              div_start;
  logic              div_done;
  logic [FracW-1:0]  div_q;
  logic [ValW:0]     d_x, d_y, d_z;
  logic signed [ValW+FracW+1:0] p_x, p_y, p_z;
  logic [1:0]        mstep;
  logic              res_valid;
  logic [TimeW:0]    num_s, den_s;
  logic              q_write;

  // Clamp count into 1..MaxKeys.
  always_comb begin
    if (key_count == '0) begin
      n_eff = NW'(1);
    end else if ({{(NW > CountW ? NW - CountW : 0){1'b0}}, key_count} > (MaxKeys)) begin
      n_eff = NW'(MaxKeys);
    end else begin
      n_eff = NW'(key_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= CountW'(1);
    end else if (cfg_we) begin
      key_count <= cfg_data;
    end
  end

  assign q_write = (state == S_IDLE) && q_valid && !q_item.is_query;
  assign q_take  = (state == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (q_write && ({{(32 - IdxW){1'b0}}, q_item.key_index} < 32'(MaxKeys))) begin
      mem_t[AW'(q_item.key_index)] <= q_item.key_time;
      mem_x[AW'(q_item.key_index)] <= q_item.value_x;
      mem_y[AW'(q_item.key_index)] <= q_item.value_y;
      mem_z[AW'(q_item.key_index)] <= q_item.value_z;
    end
    rd_t <= mem_t[rd_addr];
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
    rd_z <= mem_z[rd_addr];
  end

  assign num_s = {1'b0, qt} - {1'b0, t0};
  assign den_s = {1'b0, rd_t} - {1'b0, t0};
  assign div_start = (state == S_PAIR) && have_lo_row && !num_s[TimeW] && !den_s[TimeW]
                     && (den_s != '0) && (num_s < den_s);

  kfi_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_s[TimeW-1:0]),
    .den   (den_s[TimeW-1:0]),
    .done  (div_done),
    .quot  (div_q)
  );

  // Scan reads key scan+1 and tests it; lo is scan on first hit or at the last pair.
  always_comb begin
    rd_addr = scan + 1'b1;
    if (state == S_FETCH) begin
      rd_addr = lo;
    end else if (state == S_PAIR || state == S_DIV) begin
      rd_addr = lo + 1'b1;
    end else if (state == S_IDLE) begin
      rd_addr = (n_eff == NW'(1)) ? '0 : AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!res_valid || pop)) begin
        res_valid <= 1'b1;
      end else if (res_valid && pop) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_take && q_item.is_query) begin
            qt    <= q_item.query_time;
            scan  <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          if (n_eff == NW'(1)) begin
            s_x <= rd_x; s_y <= rd_y; s_z <= rd_z;
            lo <= '0; flag <= 1'b0;
            r_x <= rd_x; r_y <= rd_y; r_z <= rd_z;
            state <= S_OUT;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // rd_t holds key scan+1.
          if (qt < rd_t || {1'b0, scan} + 2'd2 >= {1'b0, n_eff}) begin
            lo    <= scan;
            state <= S_FETCH;
          end else begin
            scan  <= scan + 1'b1;
            state <= S_RD;
          end
        end
        S_FETCH: begin
          state <= S_PAIR;
        end
        S_PAIR: begin
          // rd_t/rd_x hold key lo on entry; latch start, then end arrives.
          if (!have_lo_row) begin
            t0 <= rd_t; s_x <= rd_x; s_y <= rd_y; s_z <= rd_z;
            have_lo_row <= 1'b1;
          end else begin
            have_lo_row <= 1'b0;
            d_x <= {rd_x[ValW-1], rd_x} - {s_x[ValW-1], s_x};
            d_y <= {rd_y[ValW-1], rd_y} - {s_y[ValW-1], s_y};
            d_z <= {rd_z[ValW-1], rd_z} - {s_z[ValW-1], s_z};
            if (num_s[TimeW]) begin
              factor <= '0; flag <= 1'b1; state <= S_MUL;
            end else if (den_s[TimeW] || den_s == '0) begin
              factor <= '0; flag <= 1'b0; state <= S_MUL;
            end else if (num_s >= den_s) begin
              factor <= {1'b1, {FracW{1'b0}}};
              flag   <= (num_s != den_s);
              state  <= S_MUL;
            end else begin
              flag  <= 1'b0;
              state <= S_DIV;
            end
          end
          mstep <= '0;
        end
        S_DIV: begin
          if (div_done) begin
            factor <= {1'b0, div_q};
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          // One component per cycle through a single multiplier.
          unique case (mstep)
            2'd0:    p_x <= $signed(d_x) * $signed({1'b0, factor});
            2'd1:    p_y <= $signed(d_y) * $signed({1'b0, factor});
            default: p_z <= $signed(d_z) * $signed({1'b0, factor});
          endcase
          mstep <= mstep + 1'b1;
          if (mstep == 2'd2) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          r_x <= s_x + ValW'((p_x + (p_x[ValW+FracW+1] ? (ValW+FracW+2)'(65535) : '0))
                 >>> FracW);
          r_y <= s_y + ValW'((p_y + (p_y[ValW+FracW+1] ? (ValW+FracW+2)'(65535) : '0))
                 >>> FracW);
          r_z <= s_z + ValW'((p_z + (p_z[ValW+FracW+1] ? (ValW+FracW+2)'(65535) : '0))
                 >>> FracW);
          state <= S_OUT;
        end
        S_OUT: begin
          // Hold the finished item until the output register frees up.
          if (!res_valid || pop) begin
            out_x          <= r_x;
            out_y          <= r_y;
            out_z          <= r_z;
            interval_start <= IdxW'(lo);
            out_of_range   <= flag;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_IDLE || state == S_FETCH) begin
        have_lo_row <= 1'b0;
      end
    end
  end

  assign empty = !res_valid;

  a_div_only: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV)) else $error("divider finished outside wait");
  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    q_take |-> (state == S_IDLE)) else $error("item taken while busy");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !pop) |=> res_valid) else $error("result dropped");

endmodule
`default_nettype wire

// ===== design/keyframe_vec3_interpolation.sv =====
// Top level of the keyframe interpolation block.
// Usage:
//   Items enter through push/full. op 0 writes one keyframe (time and x/y/z)
//   into slot key_index and gives no result; op 1 queries query_time.
//   Results leave through empty/pop: out_x/y/z, interval_start and
//   out_of_range stay on the ports while empty is low.
//   key_count is written by cfg_we/cfg_data while the block is idle.
//   A two-entry queue separates the front end from the back end, which
//   handles one item at a time.
//   A write is stored in the back end in the same cycle it is taken. A query
//   reads one key per scan step (one memory read per step), fetches the
//   pair, runs the bit-serial factor divider, takes each component through
//   the shared multiplier in turn and then finishes.
//   Reset clears the queue, the back-end state and sets key_count to 1;
//   the key store is undefined until written.
//   When pop is held low a result waits in the output register; the back
//   end keeps taking writes until one more query is computed and waits.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_vec3_interpolation import kfi_pkg::*; #(
  parameter int MAX_KEYS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              op,
  input  wire logic [IdxW-1:0]   key_index,
  input  wire logic [TimeW-1:0]  key_time,
  input  wire logic [ValW-1:0]   value_x,
  input  wire logic [ValW-1:0]   value_y,
  input  wire logic [ValW-1:0]   value_z,
  input  wire logic [TimeW-1:0]  query_time,
  input  wire logic              cfg_we,
  input  wire logic [CountW-1:0] cfg_data,
  output logic                   empty,
  input  wire logic              pop,
  output logic [ValW-1:0]        out_x,
  output logic [ValW-1:0]        out_y,
  output logic [ValW-1:0]        out_z,
  output logic [IdxW-1:0]        interval_start,
  output logic                   out_of_range
);

  logic      q_valid;
  logic      q_take;
  kfi_item_t q_item;

  kfi_front #(.Depth(2)) u_front (
    .clk, .rst, .push, .full, .op, .key_index, .key_time,
    .value_x, .value_y, .value_z, .query_time,
    .q_valid, .q_item, .q_take
  );

  kfi_back #(.MaxKeys(MAX_KEYS)) u_back (
    .clk, .rst, .cfg_we, .cfg_data, .q_valid, .q_item, .q_take,
    .empty, .pop, .out_x, .out_y, .out_z, .interval_start, .out_of_range
  );

endmodule
`default_nettype wire

// ===== test/tb_keyframe_vec3_interpolation.sv =====
// Testbench for the keyframe interpolation block: a self-checking random and directed run.
`timescale 1ns / 1ps
module tb_keyframe_vec3_interpolation;
  import kfi_pkg::*;

  localparam int MaxKeys   = 64;
  localparam int StallLimit = 6000;

  typedef struct {
    logic [ValW-1:0] x, y, z;
    logic [IdxW-1:0] start;
    logic            clamped;
  } lerp_result_t;

  logic              clk = 0;
  logic              rst = 1;
  logic              push = 0;
  logic              full;
  logic              op = OP_WRITE;
  logic [IdxW-1:0]   key_index = '0;
  logic [TimeW-1:0]  key_time = '0;
  logic [ValW-1:0]   value_x = '0, value_y = '0, value_z = '0;
  logic [TimeW-1:0]  query_time = '0;
  logic              cfg_we = 0;
  logic [CountW-1:0] cfg_data = '0;
  logic              empty;
  logic              pop = 0;
  logic [ValW-1:0]   out_x, out_y, out_z;
  logic [IdxW-1:0]   interval_start;
  logic              out_of_range;

  keyframe_vec3_interpolation uut (
    .clk, .rst, .push, .full, .op, .key_index, .key_time, .value_x, .value_y,
    .value_z, .query_time, .cfg_we, .cfg_data, .empty, .pop, .out_x, .out_y,
    .out_z, .interval_start, .out_of_range
  );

  always #2 clk = ~clk;

  // Track copy used by the predictor
  logic [TimeW-1:0]  trk_time [MaxKeys];
  logic [ValW-1:0]   trk_x [MaxKeys], trk_y [MaxKeys], trk_z [MaxKeys];
  logic [CountW-1:0] trk_count = 1;

  lerp_result_t pending_results [$];
  int errors = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int pop_mode = 0;
  int cyc = 0;

  function automatic logic [ValW-1:0] blend(logic [ValW-1:0] s, logic [ValW-1:0] e,
                                            longint f);
    longint sv, delta;
    sv = longint'($signed(s));
    delta = longint'($signed(e)) - sv;
    return ValW'(sv + (delta * f) / 65536);
  endfunction

  function automatic lerp_result_t interpolate(logic [TimeW-1:0] q);
    lerp_result_t r;
    int n, lo;
    longint num, den, f;
    n = (trk_count == 0) ? 1 : (trk_count > MaxKeys) ? MaxKeys : trk_count;
    if (n == 1) begin
      r.x = trk_x[0]; r.y = trk_y[0]; r.z = trk_z[0];
      r.start = '0; r.clamped = 0;
      return r;
    end
    lo = n - 2;
    for (int i = 0; i + 1 < n; i++) begin
      if (q < trk_time[i+1]) begin
        lo = i;
        break;
      end
    end
    num = longint'(q) - longint'(trk_time[lo]);
    den = longint'(trk_time[lo+1]) - longint'(trk_time[lo]);
    r.clamped = 0;
    if (num < 0) begin
      f = 0; r.clamped = 1;
    end else if (den <= 0) begin
      f = 0;
    end else if (num >= den) begin
      f = 65536; r.clamped = (num > den);
    end else begin
      f = (num * 65536) / den;
    end
    r.x = blend(trk_x[lo], trk_x[lo+1], f);
    r.y = blend(trk_y[lo], trk_y[lo+1], f);
    r.z = blend(trk_z[lo], trk_z[lo+1], f);
    r.start = IdxW'(lo);
    return r;
  endfunction

  // Append one expected result at the tail of the queue
  task automatic queue_expected(lerp_result_t r);
    pending_results = {pending_results, r};
  endtask

  // Drive one item, wait for it to be accepted, then update the track copy or queue its expected result
  task automatic send_item(op_t kind, logic [IdxW-1:0] idx, logic [TimeW-1:0] t,
                           logic [ValW-1:0] x, logic [ValW-1:0] y, logic [ValW-1:0] z,
                           logic [TimeW-1:0] q);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    push <= 1; op <= kind; key_index <= idx; key_time <= t;
    value_x <= x; value_y <= y; value_z <= z; query_time <= q;
    do @(posedge clk); while (full);
    if (kind == OP_WRITE) begin
      trk_time[idx] = t; trk_x[idx] = x; trk_y[idx] = y; trk_z[idx] = z;
    end else begin
      queue_expected(interpolate(q));
    end
  endtask

  task automatic write_key(int idx, logic [TimeW-1:0] t, logic [ValW-1:0] x,
                           logic [ValW-1:0] y, logic [ValW-1:0] z);
    send_item(OP_WRITE, IdxW'(idx), t, x, y, z, TimeW'($urandom));
  endtask

  task automatic query(logic [TimeW-1:0] q);
    send_item(OP_QUERY, IdxW'($urandom), TimeW'($urandom), $urandom, $urandom, $urandom, q);
  endtask

  // Drop push, drain all results, let trailing writes finish, then load key_count
  task automatic set_count(logic [CountW-1:0] v);
    push <= 0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_we <= 1; cfg_data <= v;
    @(posedge clk);
    trk_count = v;
    cfg_we <= 0;
  endtask

  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_fill_track();
    for (int i = 0; i < MaxKeys; i++)
      write_key(i, TimeW'(i * 1000), pick_value(), pick_value(), pick_value());
  endtask

  task automatic test_directed();
    set_count(1);
    query(24'h000000);
    query(24'hFFFFFF);
    set_count(0);
    query(24'h123456);
    write_key(0, 24'd100, 32'h80000000, 32'h7FFFFFFF, 32'h00000000);
    write_key(1, 24'd200, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
    set_count(2);
    query(24'd50);      // before the first key
    query(24'd100);
    query(24'd150);
    query(24'd199);
    query(24'd200);     // exactly on the last key
    query(24'hFFFFFF);  // past the last key
    write_key(1, 24'd100, 32'd5, 32'd6, 32'd7);  // zero-length interval
    query(24'd100);
    write_key(1, 24'd40, 32'd5, 32'd6, 32'd7);   // descending interval
    query(24'd100);
    query(24'd120);
    set_count(127);
    query(24'd0);
    query(24'hFFFFFF);
    set_count(64);
    query(24'h800000);
    query(24'd63000);
  endtask

  task automatic test_random_tracks();
    int n, nq;
    logic [TimeW-1:0] t, t_last;
    for (int phase = 0; phase < 40; phase++) begin
      case ($urandom_range(0, 9))
        0: n = MaxKeys;
        1: n = $urandom_range(65, 127);
        2: n = 0;
        default: n = $urandom_range(2, 10);
      endcase
      set_count(CountW'(n));
      t = ($urandom_range(0, 3) == 0) ? TimeW'($urandom) : TimeW'($urandom_range(0, 4000));
      t_last = t;
      for (int i = 0; i < ((n > MaxKeys) ? MaxKeys : (n == 0 ? 1 : n)); i++) begin
        if ($urandom_range(0, 9) == 0)
          write_key(i, TimeW'($urandom), pick_value(), pick_value(), pick_value());
        else begin
          write_key(i, t, pick_value(), pick_value(), pick_value());
          t_last = t;
          if ($urandom_range(0, 7) != 0) t = t + TimeW'($urandom_range(1, 50000));
          if (t < t_last) t = 24'hFFFFFF;
        end
      end
      nq = $urandom_range(20, 40);
      for (int k = 0; k < nq; k++) begin
        case ($urandom_range(0, 9))
          0: query(TimeW'($urandom));
          1: write_key($urandom_range(0, MaxKeys - 1), TimeW'($urandom), pick_value(),
                       pick_value(), pick_value());
          default: query(t_last + TimeW'($urandom_range(0, 60000)) - TimeW'(50000));
        endcase
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    test_fill_track();
    test_directed();
    test_random_tracks();
    push <= 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Receiver stall pattern: switch between free-running, light and heavy stalls
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 97 == 0) pop_mode <= $urandom_range(0, 2);
    case (pop_mode)
      0: pop <= 1;
      1: pop <= ($urandom_range(0, 3) != 0);
      default: pop <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h z=%h", $time, out_x, out_y, out_z);
        errors++;
      end else begin
        lerp_result_t e;
        e = pending_results.pop_front();
        if (out_x !== e.x) begin
          $display("%0t: out_x expected %h actual %h", $time, e.x, out_x); errors++;
        end
        if (out_y !== e.y) begin
          $display("%0t: out_y expected %h actual %h", $time, e.y, out_y); errors++;
        end
        if (out_z !== e.z) begin
          $display("%0t: out_z expected %h actual %h", $time, e.z, out_z); errors++;
        end
        if (interval_start !== e.start) begin
          $display("%0t: interval_start expected %0d actual %0d", $time, e.start,
                   interval_start);
          errors++;
        end
        if (out_of_range !== e.clamped) begin
          $display("%0t: out_of_range expected %b actual %b", $time, e.clamped,
                   out_of_range);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || rst)
      idle_cycles <= 0;
    else if (idle_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

endmodule
